// ----- hw/rtl/b64c_pkg.sv -----
package b64c_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET  = 1'b1;

    // Direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Alphabets; character j sits at bits [8*(LEN-1-j) +: 8]
    localparam int STD_LEN     = 64;
    localparam int SUB_LEN     = 69;
    localparam int SUB_PAD_IDX = 68;

    localparam logic [8*STD_LEN-1:0] STD_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [8*SUB_LEN-1:0] SUB_ALPHABET =
        "nlmopqQH78SkC012xyMzw9FOPGRTUfghijrI#,=AstKL3de4u6J5Dv+/*&WXYVaBNbcZE";

    localparam logic [7:0] STD_PAD = 8'h3D;  // '='
    localparam logic [7:0] SUB_PAD = SUB_ALPHABET[7:0];  // 'E'

    // Decoded character: pad flag and 6-bit value
    typedef struct packed {
        logic       is_pad;
        logic [5:0] value;
    } dec_char_t;

    // 6-bit value to character
    function automatic logic [7:0] enc_char(logic [5:0] v, logic sel);
        logic [7:0] ch;
        if (sel)
            ch = SUB_ALPHABET[8*(SUB_LEN-1-int'(v)) +: 8];
        else
            ch = STD_ALPHABET[8*(STD_LEN-1-int'(v)) +: 8];
        return ch;
    endfunction

    function automatic logic [7:0] pad_char(logic sel);
        return sel ? SUB_PAD : STD_PAD;
    endfunction

    // Character to value; unknown characters give 0
    function automatic dec_char_t dec_char(logic [7:0] c, logic sel);
        dec_char_t r;
        r = '0;
        if (sel) begin
            // Substituted alphabet has no repeated characters
            for (int j = 0; j < SUB_LEN; j++) begin
                if (SUB_ALPHABET[8*(SUB_LEN-1-j) +: 8] == c) begin
                    if (j == SUB_PAD_IDX)
                        r.is_pad = 1'b1;
                    else if (j < STD_LEN)
                        r.value = 6'(j);
                end
            end
        end else begin
            if (c == STD_PAD)
                r.is_pad = 1'b1;
            else if (c >= 8'h41 && c <= 8'h5A)
                r.value = 6'(c - 8'h41);
            else if (c >= 8'h61 && c <= 8'h7A)
                r.value = 6'(c - 8'h47);
            else if (c >= 8'h30 && c <= 8'h39)
                r.value = 6'(c + 8'h04);
            else if (c == 8'h2B)
                r.value = 6'd62;
            else if (c == 8'h2F)
                r.value = 6'd63;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/b64c_if.sv -----
// Input word channel
interface b64c_in_if;
    import b64c_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_value;
    logic       last_item;

    modport source (output valid, data_value, last_item, input ready);
    modport sink   (input valid, data_value, last_item, output ready);
endinterface

// Result word channel
interface b64c_out_if;
    import b64c_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] out_value;
    logic       out_valid;
    logic       out_last;

    modport source (output valid, out_value, out_valid, out_last, input ready);
    modport sink   (input valid, out_value, out_valid, out_last, output ready);
endinterface

// ----- hw/rtl/base64_substitution_codec.sv -----
// Streaming Base64 encoder/decoder.
// in_ch carries one byte (encode) or one character (decode) per word, with
// last_item marking the end of a message. out_ch carries the resulting
// characters or bytes; out_last flags the final result of a message, and
// out_valid is low only on the empty closing word a decode message may end with.
// direction and alphabet_select are written through cfg_we/cfg_index/cfg_data;
// a write also restarts the group state. The user must write them only while
// the block is idle; the block itself does not enforce this. An accepted word
// is held in the input register, then turned into its result group in the
// result group register, which offers its results. Throughput is one input word
// per cycle while out_ch does not stall and each word yields at most one result;
// the result group register drains one result per cycle while out_ch is ready;
// a group-closing encode word gives two results, a final encode word up to four.
// When out_ch stalls, the group register holds and the input register fills,
// then in_ch.ready drops. Reset clears the configuration to encode with the
// standard alphabet, the group state, and both pipeline registers.
module base64_substitution_codec
    import b64c_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    b64c_in_if.sink               in_ch,
    b64c_out_if.source            out_ch
);

    // Configuration and group state
    logic       direction_reg;
    logic       alpha_sel_reg;
    logic [1:0] phase_reg,  phase_next;
    logic [5:0] carry_reg,  carry_next;

    // Input register
    logic       inr_valid_reg;
    logic [7:0] inr_data_reg;
    logic       inr_last_reg;

    // Result group register
    logic [7:0] grp_val_reg [4];
    logic [1:0] grp_cnt_reg;
    logic [1:0] grp_idx_reg;
    logic       grp_valid_reg;
    logic       grp_dvalid_reg;
    logic       grp_last_reg;

    // Results of the word in the input register
    logic [7:0] res_val [4];
    logic [1:0] res_cnt;
    logic       res_any;
    logic       res_dvalid;

    logic       grp_done;
    logic       grp_free;
    logic       advance;
    logic       grp_at_end;
    dec_char_t  dch;
    logic [5:0] enc_idx0;
    logic [5:0] enc_idx1;

    // Handshake control
    assign grp_at_end = (grp_idx_reg == grp_cnt_reg);
    assign grp_done   = grp_valid_reg & out_ch.ready & grp_at_end;
    assign grp_free   = ~grp_valid_reg | grp_done;
    assign advance    = inr_valid_reg & grp_free;
    assign in_ch.ready = ~inr_valid_reg | advance;

    // Encode/decode of one word
    always_comb
    begin
        phase_next = phase_reg;
        carry_next = carry_reg;
        enc_idx0   = '0;
        enc_idx1   = '0;
        res_cnt    = '0;
        res_any    = 1'b0;
        res_dvalid = 1'b1;
        dch        = dec_char(inr_data_reg, alpha_sel_reg);
        for (int k = 0; k < 4; k++)
            res_val[k] = pad_char(alpha_sel_reg);

        if (direction_reg == DIR_ENCODE) begin
            res_any = 1'b1;
            unique case (phase_reg)
                2'd1:
                begin
                    enc_idx0   = carry_reg | {2'b00, inr_data_reg[7:4]};
                    carry_next = {inr_data_reg[3:0], 2'b00};
                    phase_next = 2'd2;
                end
                2'd2:
                begin
                    enc_idx0   = carry_reg | {4'b0000, inr_data_reg[7:6]};
                    carry_next = '0;
                    phase_next = 2'd0;
                end
                default:
                begin
                    // phase three cannot occur here; it acts as phase zero
                    enc_idx0   = inr_data_reg[7:2];
                    carry_next = {inr_data_reg[1:0], 4'b0000};
                    phase_next = 2'd1;
                end
            endcase
            // second character: low six bits of a full group, else the tail
            enc_idx1 = (phase_reg == 2'd2) ? inr_data_reg[5:0] : carry_next;
            if (phase_reg == 2'd2)
                res_cnt = 2'd1;
            else if (inr_last_reg && phase_next == 2'd1)
                res_cnt = 2'd3;
            else if (inr_last_reg && phase_next == 2'd2)
                res_cnt = 2'd2;
            res_val[0] = enc_char(enc_idx0, alpha_sel_reg);
            res_val[1] = enc_char(enc_idx1, alpha_sel_reg);
        end else begin
            res_val[0] = '0;
            if (!dch.is_pad) begin
                phase_next = phase_reg + 2'd1;
                unique case (phase_reg)
                    2'd0:
                    begin
                        carry_next = dch.value;
                    end
                    2'd1:
                    begin
                        res_any    = 1'b1;
                        res_val[0] = {carry_reg, dch.value[5:4]};
                        carry_next = {2'b00, dch.value[3:0]};
                    end
                    2'd2:
                    begin
                        res_any    = 1'b1;
                        res_val[0] = {carry_reg[3:0], dch.value[5:2]};
                        carry_next = {4'b0000, dch.value[1:0]};
                    end
                    default:
                    begin
                        res_any    = 1'b1;
                        res_val[0] = {carry_reg[1:0], dch.value};
                        carry_next = '0;
                    end
                endcase
            end
            // empty closing word
            if (!res_any && inr_last_reg) begin
                res_any    = 1'b1;
                res_dvalid = 1'b0;
            end
        end

        if (inr_last_reg) begin
            phase_next = '0;
            carry_next = '0;
        end
    end

    // Configuration and group state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            direction_reg <= DIR_ENCODE;
            alpha_sel_reg <= 1'b0;
            phase_reg     <= '0;
            carry_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DIRECTION: direction_reg <= cfg_data[0];
                REG_ALPHABET:  alpha_sel_reg <= cfg_data[0];
                default:       ;
            endcase
            phase_reg <= '0;
            carry_reg <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            inr_valid_reg <= 1'b0;
        end else if (in_ch.ready) begin
            inr_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready) begin
            inr_data_reg <= in_ch.data_value;
            inr_last_reg <= in_ch.last_item;
        end
    end

    // Result group control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            grp_valid_reg <= 1'b0;
            grp_idx_reg   <= '0;
        end else if (advance && res_any) begin
            grp_valid_reg <= 1'b1;
            grp_idx_reg   <= '0;
        end else if (grp_done) begin
            grp_valid_reg <= 1'b0;
            grp_idx_reg   <= '0;
        end else if (grp_valid_reg && out_ch.ready) begin
            grp_idx_reg <= grp_idx_reg + 2'd1;
        end
    end

    // Result group payload
    always_ff @(posedge clk)
    begin
        if (advance && res_any) begin
            grp_val_reg    <= res_val;
            grp_cnt_reg    <= res_cnt;
            grp_dvalid_reg <= res_dvalid;
            grp_last_reg   <= inr_last_reg;
        end
    end

    // Output word
    assign out_ch.valid     = grp_valid_reg;
    assign out_ch.out_value = grp_val_reg[grp_idx_reg];
    assign out_ch.out_valid = grp_dvalid_reg;
    assign out_ch.out_last  = grp_last_reg & grp_at_end;

`ifndef SYNTHESIS
    // Empty closing word is a single, final result
    a_empty_close: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid_reg && !grp_dvalid_reg) |-> (grp_cnt_reg == 2'd0 && grp_last_reg))
        else $error("empty closing word not a single final result");

    // Group state restarts after the last word of a message
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && inr_last_reg) |=> (phase_reg == 2'd0 && carry_reg == 6'd0))
        else $error("group state not cleared after last word");

    // Encoding never reaches phase three
    a_enc_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (direction_reg == DIR_ENCODE) |-> (phase_reg != 2'd3))
        else $error("encode reached phase three");
`endif

endmodule
